// ----- hw/rtl/line_position_pd_steer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the line position PD steering block
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_PD_STEER_ASSERT_SVH
`define LINE_POSITION_PD_STEER_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent and consequent in the same cycle.
`define LPPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lpps check failed");

// Consequent in the cycle after the antecedent.
`define LPPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lpps check failed");

`else

`define LPPS_ASSERT_SAME(label, ante, cons)
`define LPPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hw/rtl/lpps_pkg.sv -----
// ----------------------------------------------------------------------------
// lpps_pkg
// Shared widths, limits, reset values and register indexes.
// ----------------------------------------------------------------------------
package lpps_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF   = 12;

    localparam int ERR_BITS   = 15;
    localparam int DELTA_BITS = 16;
    localparam int TURN_BITS  = 16;
    localparam int GAIN_BITS  = 16;

    // Operand width inside the serial multiplier and width of its product.
    localparam int MUL_ACC_BITS = DELTA_BITS + 2;
    localparam int PROD_BITS    = MUL_ACC_BITS + GAIN_BITS;

    localparam int ERR_POS_LIMIT = (1 << (ERR_BITS - 1)) - 1;
    localparam int ERR_NEG_LIMIT = 1 << (ERR_BITS - 1);
    localparam int TURN_MAX      = (1 << (TURN_BITS - 1)) - 1;
    localparam int TURN_MIN      = -(1 << (TURN_BITS - 1));

    localparam int OUT_DATA_BITS = ((ERR_BITS + DELTA_BITS + TURN_BITS + 7) / 8) * 8;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [GAIN_BITS-1:0] GAIN_PROP_RESET  = 16'd860;
    localparam logic [GAIN_BITS-1:0] GAIN_DERIV_RESET = 16'd0;

    // Register index, taken from paddr[2].
    localparam logic REG_GAIN_PROP  = 1'b0;
    localparam logic REG_GAIN_DERIV = 1'b1;

endpackage

// ----- hw/rtl/lpps_div.sv -----
// ----------------------------------------------------------------------------
// lpps_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpps_div #(
    parameter int SAMPLE_BITS = lpps_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = lpps_pkg::FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [SAMPLE_BITS+1:0] dividend,
    input  logic [SAMPLE_BITS+2:0] divisor,
    output logic                   done,
    output logic [FRAC_BITS+1:0]   quotient
);

    localparam int QW = FRAC_BITS + 2;
    localparam int RW = SAMPLE_BITS + 3;
    localparam int CW = $clog2(QW);

    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] dvs_reg, dvs_next;
    logic [QW-1:0] shf_reg, shf_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          fits;

    // The dividend is |num| << FRAC_BITS. Since |num| < 4 * sum, the top part
    // |num| >> 2 is already below the divisor and seeds the remainder, so only
    // the last two bits of |num| and the fraction zeros remain to be shifted in.
    assign trial = {rem_reg, shf_reg[QW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shf_next  = shf_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = RW'(dividend[SAMPLE_BITS+1:2]);
            dvs_next  = divisor;
            shf_next  = {dividend[1:0], {FRAC_BITS{1'b0}}};
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[RW-1:0] : trial[RW-1:0];
            shf_next = {shf_reg[QW-2:0], 1'b0};
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            shf_reg  <= shf_next;
            quo_reg  <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/lpps_mul.sv -----
// ----------------------------------------------------------------------------
// lpps_mul
// Bit-serial dual multiply-accumulate: err * kp + delta * kd, one gain bit
// per cycle, least significant first, product bits shifted out to the right.
// ----------------------------------------------------------------------------
module lpps_mul (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [lpps_pkg::ERR_BITS-1:0]   err,
    input  logic signed [lpps_pkg::DELTA_BITS-1:0] delta,
    input  logic signed [lpps_pkg::GAIN_BITS-1:0]  gain_p,
    input  logic signed [lpps_pkg::GAIN_BITS-1:0]  gain_d,
    output logic                                 done,
    output logic signed [lpps_pkg::PROD_BITS-1:0]  product
);

    localparam int AW = lpps_pkg::MUL_ACC_BITS;
    localparam int GW = lpps_pkg::GAIN_BITS;
    localparam int CW = $clog2(GW);

    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] b_reg, b_next;
    logic [GW-1:0] gp_reg, gp_next;
    logic [GW-1:0] gd_reg, gd_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [GW-1:0] lo_reg, lo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [AW-1:0] sel;
    logic [AW-1:0] tsum;
    logic          last;

    // The gains are two's complement, so the weight of their top bit is negative.
    assign last = (cnt_reg == CW'(GW - 1));
    assign sel  = (gp_reg[0] ? a_reg : '0) + (gd_reg[0] ? b_reg : '0);
    assign tsum = last ? (hi_reg - sel) : (hi_reg + sel);

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        gp_next   = gp_reg;
        gd_next   = gd_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = AW'(err);
            b_next    = AW'(delta);
            gp_next   = gain_p;
            gd_next   = gain_d;
            hi_next   = '0;
            lo_next   = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next  = {tsum[AW-1], tsum[AW-1:1]};
            lo_next  = {tsum[0], lo_reg[GW-1:1]};
            gp_next  = {1'b0, gp_reg[GW-1:1]};
            gd_next  = {1'b0, gd_reg[GW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            gp_reg   <= gp_next;
            gd_reg   <= gd_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ----- hw/rtl/line_position_pd_steer.sv -----
// ----------------------------------------------------------------------------
// line_position_pd_steer
// Line position estimate from five line sensors with PD steering output.
// ----------------------------------------------------------------------------
// Usage: each item on the s_ stream carries five sensor samples. The block
// forms the weighted line position (weights -3, -1, 0, +1, +3 over the sum
// of all samples) in signed Q.FRAC_BITS, its change from the previous item,
// and the steering rate (error * gain_prop + change * gain_deriv) >> FRAC_BITS,
// saturated to 16 bits. One result item leaves on the m_ stream per input.
// Steps: an accepted item passes ST_PREP (sums and sign), ST_DIV (bit-serial
// divider, FRAC_BITS + 2 steps), ST_MSTART, ST_MUL (bit-serial multiplier, 16
// steps) and ST_FINISH, which loads the output register. One item is in work
// at a time; the next is taken only once the block is back in ST_IDLE.
// The result sits in an output register, so the next item is accepted while
// the previous result still waits; if the receiver stalls, the finished result
// of the next item is held inside until the output register frees up.
// Reset clears the previous error to zero and loads the gains with their
// defaults (gain_prop 860, gain_deriv 0). The user must write the gains over the
// APB port only while no item is in work; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "line_position_pd_steer_assert.svh"

module line_position_pd_steer #(
    parameter int SAMPLE_BITS = lpps_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = lpps_pkg::FRAC_BITS_DEF,
    localparam int IN_DATA_BITS = ((5 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    // Input stream.
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0 up: sample_far_left, sample_left, sample_center,
    // sample_right, sample_far_right, then zero fill.
    input  logic [IN_DATA_BITS-1:0]                 s_tdata,

    // Result stream.
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // Fields from bit 0 up: position_error, error_delta, turn_rate, zero fill.
    output logic [lpps_pkg::OUT_DATA_BITS-1:0]      m_tdata,
    // Fields from bit 0 up: no_signal.
    output logic                                    m_tuser,

    // Configuration port.
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [lpps_pkg::CFG_ADDR_BITS-1:0]      paddr,
    input  logic [lpps_pkg::CFG_DATA_BITS-1:0]      pwdata,
    output logic [lpps_pkg::CFG_DATA_BITS-1:0]      prdata,
    output logic                                    pready
);

    localparam int EB = lpps_pkg::ERR_BITS;
    localparam int DB = lpps_pkg::DELTA_BITS;
    localparam int TB = lpps_pkg::TURN_BITS;
    localparam int GB = lpps_pkg::GAIN_BITS;
    localparam int PB = lpps_pkg::PROD_BITS;
    localparam int NW = SAMPLE_BITS + 3;
    localparam int QW = FRAC_BITS + 2;
    localparam int EW = (QW > EB ? QW : EB) + 1;

    localparam logic signed [PB-1:0] TURN_HI = PB'(lpps_pkg::TURN_MAX);
    localparam logic signed [PB-1:0] TURN_LO = PB'(lpps_pkg::TURN_MIN);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MSTART,
        ST_MUL,
        ST_FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic [SAMPLE_BITS-1:0]    samp_reg [5];
    logic [SAMPLE_BITS-1:0]    samp_next [5];
    logic                      neg_reg, neg_next;
    logic                      none_reg, none_next;
    logic signed [EB-1:0]      err_reg, err_next;
    logic signed [DB-1:0]      delta_reg, delta_next;
    logic signed [EB-1:0]      prev_reg, prev_next;
    logic [GB-1:0]             gp_reg, gp_next;
    logic [GB-1:0]             gd_reg, gd_next;
    logic                      m_valid_reg, m_valid_next;
    logic [EB-1:0]             out_err_reg, out_err_next;
    logic [DB-1:0]             out_delta_reg, out_delta_next;
    logic [TB-1:0]             out_turn_reg, out_turn_next;
    logic                      out_none_reg, out_none_next;

    // Datapath signals.
    logic [NW-1:0]             ext [5];
    logic [NW-1:0]             sum_c;
    logic [NW-1:0]             outer_c;
    logic [NW-1:0]             num_c;
    logic [NW-1:0]             mag_c;
    logic                      s_accept;
    logic                      cfg_write;
    logic                      cfg_idx;
    logic                      div_start;
    logic                      div_done;
    logic [QW-1:0]             quotient;
    logic [EW-1:0]             q_wide;
    logic signed [EB-1:0]      err_c;
    logic                      mul_start;
    logic                      mul_done;
    logic signed [PB-1:0]      product;
    logic signed [PB-1:0]      shifted;
    logic [TB-1:0]             turn_c;

    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[2];

    // Weighted sum and plain sum of the stored samples. All terms stay within
    // NW bits: the sum is below 5 * 2^SAMPLE_BITS and |num| below 4 * 2^SAMPLE_BITS.
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            ext[i] = NW'(samp_reg[i]);
        end
    end

    assign sum_c   = ext[0] + ext[1] + ext[2] + ext[3] + ext[4];
    assign outer_c = ext[4] - ext[0];
    assign num_c   = (outer_c << 1) + outer_c + ext[3] - ext[1];
    assign mag_c   = num_c[NW-1] ? (~num_c + 1'b1) : num_c;

    assign div_start = (state_reg == ST_PREP);
    assign mul_start = (state_reg == ST_MSTART);

    lpps_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_c[SAMPLE_BITS+1:0]),
        .divisor  (sum_c),
        .done     (div_done),
        .quotient (quotient)
    );

    lpps_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .err     (err_reg),
        .delta   (delta_reg),
        .gain_p  (gp_reg),
        .gain_d  (gd_reg),
        .done    (mul_done),
        .product (product)
    );

    // Signed position from the quotient magnitude, saturated to the error
    // range. A zero sample sum forces the position to zero.
    assign q_wide = EW'(quotient);

    always_comb begin
        if (none_reg) begin
            err_c = '0;
        end else if (neg_reg) begin
            if (q_wide > EW'(lpps_pkg::ERR_NEG_LIMIT)) begin
                err_c = EB'(-lpps_pkg::ERR_NEG_LIMIT);
            end else begin
                err_c = ~q_wide[EB-1:0] + 1'b1;
            end
        end else begin
            if (q_wide > EW'(lpps_pkg::ERR_POS_LIMIT)) begin
                err_c = EB'(lpps_pkg::ERR_POS_LIMIT);
            end else begin
                err_c = q_wide[EB-1:0];
            end
        end
    end

    // The arithmetic shift rounds toward minus infinity, then the result is
    // saturated to the 16-bit steering range.
    assign shifted = product >>> FRAC_BITS;

    always_comb begin
        if (shifted > TURN_HI) begin
            turn_c = TB'(lpps_pkg::TURN_MAX);
        end else if (shifted < TURN_LO) begin
            turn_c = TB'(lpps_pkg::TURN_MIN);
        end else begin
            turn_c = shifted[TB-1:0];
        end
    end

    // Register reads return the gain sign-extended to the bus width.
    always_comb begin
        unique case (cfg_idx)
            lpps_pkg::REG_GAIN_PROP:  prdata = {{(lpps_pkg::CFG_DATA_BITS-GB){gp_reg[GB-1]}},
                                                gp_reg};
            lpps_pkg::REG_GAIN_DERIV: prdata = {{(lpps_pkg::CFG_DATA_BITS-GB){gd_reg[GB-1]}},
                                                gd_reg};
        endcase
    end

    // Sequencer and registers.
    always_comb begin
        state_next     = state_reg;
        samp_next      = samp_reg;
        neg_next       = neg_reg;
        none_next      = none_reg;
        err_next       = err_reg;
        delta_next     = delta_reg;
        prev_next      = prev_reg;
        gp_next        = gp_reg;
        gd_next        = gd_reg;
        m_valid_next   = m_valid_reg;
        out_err_next   = out_err_reg;
        out_delta_next = out_delta_reg;
        out_turn_next  = out_turn_reg;
        out_none_next  = out_none_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_write) begin
            if (cfg_idx == lpps_pkg::REG_GAIN_PROP) begin
                gp_next = pwdata[GB-1:0];
            end else begin
                gd_next = pwdata[GB-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    for (int i = 0; i < 5; i++) begin
                        samp_next[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                neg_next   = num_c[NW-1];
                none_next  = (sum_c == '0);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    err_next   = err_c;
                    delta_next = {err_c[EB-1], err_c} - {prev_reg[EB-1], prev_reg};
                    prev_next  = err_c;
                    state_next = ST_MSTART;
                end
            end
            ST_MSTART: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    out_err_next   = err_reg;
                    out_delta_next = delta_reg;
                    out_turn_next  = turn_c;
                    out_none_next  = none_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            prev_reg    <= '0;
            gp_reg      <= lpps_pkg::GAIN_PROP_RESET;
            gd_reg      <= lpps_pkg::GAIN_DERIV_RESET;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            prev_reg      <= prev_next;
            gp_reg        <= gp_next;
            gd_reg        <= gd_next;
            samp_reg      <= samp_next;
            neg_reg       <= neg_next;
            none_reg      <= none_next;
            err_reg       <= err_next;
            delta_reg     <= delta_next;
            out_err_reg   <= out_err_next;
            out_delta_reg <= out_delta_next;
            out_turn_reg  <= out_turn_next;
            out_none_reg  <= out_none_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lpps_pkg::OUT_DATA_BITS-EB-DB-TB){1'b0}},
                       out_turn_reg, out_delta_reg, out_err_reg};
    assign m_tuser  = out_none_reg;
    assign pready   = 1'b1;

    // The divider and the multiplier only finish while the sequencer waits on them.
    `LPPS_ASSERT_SAME(a_div_done_in_div, div_done, state_reg == ST_DIV)
    `LPPS_ASSERT_SAME(a_mul_done_in_mul, mul_done, state_reg == ST_MUL)
    // An accepted item always moves on to the sum stage.
    `LPPS_ASSERT_NEXT(a_accept_to_prep, s_accept, state_reg == ST_PREP)
    // A result without line signal carries a zero position.
    `LPPS_ASSERT_SAME(a_no_signal_zero, m_valid_reg && out_none_reg, out_err_reg == '0)

endmodule

// ----- tb/sv/tb_line_position_pd_steer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_position_pd_steer
// Self-checking bench for the line position PD steering block.
// ----------------------------------------------------------------------------
// Sensor sample sets are streamed into the block while the result stream is
// stalled in random bursts. A bench-side model of the position estimate, the
// error change and the saturated PD rate predicts every result item, and each
// result item is compared field by field with the oldest prediction. The
// gains are reloaded over APB between phases, always with the block drained,
// and the run covers the reset gains, both extremes and random settings.
// ----------------------------------------------------------------------------
module tb_line_position_pd_steer;

    localparam int IN_BITS        = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 48;

    // One set of sensor samples; far_left ends up in the lowest bits.
    typedef struct packed {
        logic [11:0] far_right;
        logic [11:0] right;
        logic [11:0] center;
        logic [11:0] left;
        logic [11:0] far_left;
    } sample_set_t;

    // One steering result as it should leave the block.
    typedef struct packed {
        logic                            no_signal;
        logic [lpps_pkg::TURN_BITS-1:0]  turn;
        logic [lpps_pkg::DELTA_BITS-1:0] delta;
        logic [lpps_pkg::ERR_BITS-1:0]   err;
    } steer_result_t;

    // Clock, reset and every block input start at known values.
    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic [IN_BITS-1:0]                 s_tdata  = '0;
    logic                               m_tready = 1'b0;
    logic                               psel     = 1'b0;
    logic                               penable  = 1'b0;
    logic                               pwrite   = 1'b0;
    logic [lpps_pkg::CFG_ADDR_BITS-1:0] paddr    = '0;
    logic [lpps_pkg::CFG_DATA_BITS-1:0] pwdata   = '0;

    logic                               s_tready;
    logic                               m_tvalid;
    logic [lpps_pkg::OUT_DATA_BITS-1:0] m_tdata;   // position_error, error_delta, turn_rate
    logic                               m_tuser;   // no_signal
    logic [lpps_pkg::CFG_DATA_BITS-1:0] prdata;
    logic                               pready;

    // Bench copy of the block's registers and its single piece of state.
    logic signed [lpps_pkg::GAIN_BITS-1:0] gain_prop_copy  = lpps_pkg::GAIN_PROP_RESET;
    logic signed [lpps_pkg::GAIN_BITS-1:0] gain_deriv_copy = lpps_pkg::GAIN_DERIV_RESET;
    int                                    last_position   = 0;

    sample_set_t   sample_sets[$];      // sets waiting to be sent
    steer_result_t steer_expected[$];   // predictions waiting for their result
    sample_set_t   set_on_bus;
    int            sets_queued   = 0;
    int            results_taken = 0;
    int            fail_count    = 0;
    int            send_gap      = 0;
    int            recv_stall    = 0;
    int            quiet_cycles  = 0;
    bit            no_idling     = 1'b0;

    line_position_pd_steer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Steering prediction for one sample set. The position is the weighted
    // sum scaled to Q.12 and divided by the sample sum, truncated toward zero.
    // The PD sum is exact in 64 bits and the arithmetic shift floors it.
    // The function also moves the remembered position forward.
    function automatic steer_result_t predict_steering(input sample_set_t smp);
        int            weighted;
        int            total;
        int            quotient;
        int            position;
        int            change;
        int            rate;
        longint        pd_sum;
        longint        pd_scaled;
        steer_result_t res;
        weighted = 3 * int'(smp.far_right) + int'(smp.right)
                 - int'(smp.left) - 3 * int'(smp.far_left);
        total = int'(smp.far_left) + int'(smp.left) + int'(smp.center)
              + int'(smp.right) + int'(smp.far_right);
        if (total == 0) begin
            // No line seen at all: the position is forced to the center.
            position = 0;
        end else begin
            quotient = ((weighted < 0) ? -weighted : weighted) * 4096 / total;
            position = (weighted < 0) ? -quotient : quotient;
            if (position > lpps_pkg::ERR_POS_LIMIT)
                position = lpps_pkg::ERR_POS_LIMIT;
            if (position < -lpps_pkg::ERR_NEG_LIMIT)
                position = -lpps_pkg::ERR_NEG_LIMIT;
        end
        change = position - last_position;
        if (change > 32767)
            change = 32767;
        if (change < -32768)
            change = -32768;
        pd_sum = longint'(position) * longint'(gain_prop_copy)
               + longint'(change) * longint'(gain_deriv_copy);
        pd_scaled = pd_sum >>> 12;
        if (pd_scaled > longint'(lpps_pkg::TURN_MAX))
            rate = lpps_pkg::TURN_MAX;
        else if (pd_scaled < longint'(lpps_pkg::TURN_MIN))
            rate = lpps_pkg::TURN_MIN;
        else
            rate = int'(pd_scaled);
        last_position = position;
        res.err       = position[lpps_pkg::ERR_BITS-1:0];
        res.delta     = change[lpps_pkg::DELTA_BITS-1:0];
        res.turn      = rate[lpps_pkg::TURN_BITS-1:0];
        res.no_signal = (total == 0);
        return res;
    endfunction

    // Input side. A set stays on the bus until it is taken; the prediction is
    // made at the edge that takes it, so it sees the gains in force then.
    // Random gaps are put between sets.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                steer_expected.push_back(predict_steering(set_on_bus));
                if (!no_idling && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 4);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (sample_sets.size() > 0) begin
                    set_on_bus = sample_sets.pop_front();
                    s_tdata  <= {{(IN_BITS - $bits(sample_set_t)){1'b0}}, set_on_bus};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side. Every result item taken is checked against the oldest
    // prediction; m_tready drops in random bursts.
    always @(posedge aclk) begin : result_side
        steer_result_t want;
        steer_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_taken = results_taken + 1;
                got.err       = m_tdata[lpps_pkg::ERR_BITS-1:0];
                got.delta     = m_tdata[lpps_pkg::ERR_BITS +: lpps_pkg::DELTA_BITS];
                got.turn      = m_tdata[lpps_pkg::ERR_BITS + lpps_pkg::DELTA_BITS +:
                                        lpps_pkg::TURN_BITS];
                got.no_signal = m_tuser;
                if (steer_expected.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result: err %0d delta %0d turn %0d ns %0b",
                                 $realtime, $signed(got.err), $signed(got.delta),
                                 $signed(got.turn), got.no_signal);
                end else begin
                    want = steer_expected.pop_front();
                    if (got.err !== want.err || got.delta !== want.delta ||
                        got.turn !== want.turn || got.no_signal !== want.no_signal) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10) begin
                            $display("[%0t] mismatch: expected err %0d delta %0d turn %0d ns %0b",
                                     $realtime, $signed(want.err), $signed(want.delta),
                                     $signed(want.turn), want.no_signal);
                            $display("    got err %0d delta %0d turn %0d ns %0b",
                                     $signed(got.err), $signed(got.delta),
                                     $signed(got.turn), got.no_signal);
                        end
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall = recv_stall - 1;
                m_tready <= 1'b0;
            end else if (!no_idling && $urandom_range(0, 5) == 0) begin
                recv_stall = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a correct block keeps taking or delivering items, so a long
    // stretch with no handshake at all means it is stuck.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // One APB write: setup cycle, then access cycle until pready. The upper
    // half of pwdata carries junk, since only the low 16 bits form the gain.
    task automatic write_gain(input logic index,
                              input logic [lpps_pkg::GAIN_BITS-1:0] value);
        logic [15:0] junk;
        junk = 16'($urandom());
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {junk, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (index == lpps_pkg::REG_GAIN_PROP)
            gain_prop_copy = value;
        else
            gain_deriv_copy = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_gains(input logic [lpps_pkg::GAIN_BITS-1:0] prop,
                              input logic [lpps_pkg::GAIN_BITS-1:0] deriv);
        write_gain(lpps_pkg::REG_GAIN_PROP, prop);
        write_gain(lpps_pkg::REG_GAIN_DERIV, deriv);
    endtask

    // Every set produces exactly one result, so once all results are back
    // the block holds nothing and the gains may be changed.
    task automatic wait_drained();
        while (results_taken != sets_queued)
            @(posedge aclk);
    endtask

    task automatic add_set(input logic [11:0] fl, input logic [11:0] l,
                           input logic [11:0] c, input logic [11:0] r,
                           input logic [11:0] fr);
        sample_set_t smp;
        smp.far_left  = fl;
        smp.left      = l;
        smp.center    = c;
        smp.right     = r;
        smp.far_right = fr;
        sample_sets.push_back(smp);
        sets_queued = sets_queued + 1;
    endtask

    // Corner sets: no signal, full scale, the line on each outer sensor in
    // turn (largest jumps of the change), center only, the left and right sensor
    // alone, alternating bit patterns and a small negative truncation toward zero.
    task automatic add_corner_sets();
        add_set(12'd0,    12'd0,    12'd0,    12'd0,    12'd0);
        add_set(12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF);
        add_set(12'hFFF,  12'd0,    12'd0,    12'd0,    12'd0);
        add_set(12'd0,    12'd0,    12'd0,    12'd0,    12'hFFF);
        add_set(12'hFFF,  12'd0,    12'd0,    12'd0,    12'd0);
        add_set(12'd0,    12'd0,    12'hFFF,  12'd0,    12'd0);
        add_set(12'd0,    12'd1,    12'd0,    12'd0,    12'd0);
        add_set(12'd0,    12'd0,    12'd0,    12'hFFF,  12'd0);
        add_set(12'd0,    12'd0,    12'd0,    12'd0,    12'd0);
        add_set(12'hAAA,  12'h555,  12'hAAA,  12'h555,  12'hAAA);
        add_set(12'h555,  12'hAAA,  12'h555,  12'hAAA,  12'h555);
        add_set(12'd1,    12'd0,    12'hFFE,  12'd0,    12'd0);
    endtask

    // Random sets: fully random ones, sets shaped like a real line under the
    // sensors (low background with one or two neighboring sensors high), and
    // all-or-nothing, single-sensor and no-signal sets.
    task automatic run_random(input int count);
        logic [11:0] v[5];
        int          pick;
        int          spot;
        repeat (count) begin
            pick = $urandom_range(0, 19);
            for (int k = 0; k < 5; k++)
                v[k] = 12'd0;
            if (pick < 8) begin
                for (int k = 0; k < 5; k++)
                    v[k] = 12'($urandom_range(0, 4095));
            end else if (pick < 15) begin
                for (int k = 0; k < 5; k++)
                    v[k] = 12'($urandom_range(0, 200));
                spot = $urandom_range(0, 4);
                v[spot] = 12'($urandom_range(2000, 4095));
                if (spot < 4 && $urandom_range(0, 1) == 1)
                    v[spot + 1] = 12'($urandom_range(1000, 4095));
            end else if (pick < 17) begin
                for (int k = 0; k < 5; k++)
                    v[k] = ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'd0;
            end else if (pick < 19) begin
                v[$urandom_range(0, 4)] = 12'($urandom_range(1, 4095));
            end
            add_set(v[0], v[1], v[2], v[3], v[4]);
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset gains first, so their defaults are checked as well.
        add_corner_sets();
        wait_drained();

        // Both gains at the positive extreme drive the rate into saturation.
        load_gains(16'sd32767, 16'sd32767);
        add_corner_sets();
        run_random(200);

        load_gains(-16'sd32768, -16'sd32768);
        run_random(200);

        load_gains(16'sd32767, -16'sd32768);
        run_random(200);

        load_gains(16'sd0, 16'sd0);
        run_random(326);

        load_gains(-16'sd32768, 16'sd32767);
        run_random(200);

        load_gains(16'($urandom()), 16'($urandom()));
        run_random(200);

        load_gains(16'($urandom()), 16'($urandom()));
        run_random(200);

        // Last stretch runs at full rate on both sides.
        load_gains(16'sd860, 16'sd2048);
        no_idling = 1'b1;
        run_random(250);

        // Leave time for any result that should not be there to show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && steer_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
